/* design/ssbr_pkg.sv */
// Package for the supersample box resolve: sequencer states, register map and channel codes.
`default_nettype none

package ssbr_pkg;

  // Channel width of one sample and of one pixel.
  localparam int unsigned ChanW = 8;

  // Register map (byte addresses).
  localparam logic [2:0] RegScaleFactor = 3'd0;

  // Result slots, also the order the divider walks through them.
  localparam logic [1:0] SelRed   = 2'd0;
  localparam logic [1:0] SelGreen = 2'd1;
  localparam logic [1:0] SelBlue  = 2'd2;
  localparam logic [1:0] SelAlpha = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL_R = 6'b000010,
    ST_MUL_G = 6'b000100,
    ST_MUL_B = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_DIV   = 6'b100000
  } state_e;

  typedef logic [ChanW-1:0] chan_t;

endpackage

`default_nettype wire

/* design/supersample_box_resolve.sv */
// Supersample box resolve: alpha-weighted box downsample of RGBA sample blocks.
// Each sample is accepted in IDLE and then takes three shared-multiplier passes (MUL_R, MUL_G,
//   MUL_B); no new sample is taken until it is back in IDLE. The last sample of a block
//   adds 4 divisions (load plus 8 restoring steps on one shared divider) and the output register.
// Factor 1 is a pass-through: one sample per cycle unless the output stalls; result in the next cycle.
// Reset (rst_ni low, asynchronous): factor 1, accumulators and count clear, no beat pending.
`default_nettype none

module supersample_box_resolve
  import ssbr_pkg::*;
#(
  parameter int unsigned MAX_FACTOR = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample stream; tdata: sample_red, sample_green, sample_blue, sample_alpha (low bit up)
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  // pixel stream; tdata: pixel_red, pixel_green, pixel_blue, pixel_alpha (low bit up)
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Derived sizes: largest block, count, alpha sum, weighted sums, divider datapath.
  localparam int unsigned NMax  = MAX_FACTOR * MAX_FACTOR;
  localparam int unsigned NW    = $clog2(NMax + 1);
  localparam int unsigned AsumW = $clog2(255 * NMax + 1);
  localparam int unsigned WsumW = $clog2(65025 * NMax + 1);
  localparam int unsigned DivW  = WsumW + 9;
  localparam logic [3:0]  MaxF  = 4'(MAX_FACTOR);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [2:0] scale_q, scale_d;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == RegScaleFactor);
  assign prdata = (paddr == RegScaleFactor) ? {29'd0, scale_q} : 32'd0;

  always_comb begin
    scale_d = scale_q;
    if (cfg_wr) begin
      scale_d = pwdata[2:0];
    end
  end

  // Effective factor: zero reads as one, saturate at MAX_FACTOR.
  logic [2:0]    fac;
  logic [5:0]    fac_sq;
  logic [NW-1:0] n_w;

  always_comb begin
    fac = scale_q;
    if (scale_q == 3'd0) begin
      fac = 3'd1;
    end else if ({1'b0, scale_q} > MaxF) begin
      fac = MaxF[2:0];
    end
  end

  assign fac_sq = {3'd0, fac} * {3'd0, fac};
  assign n_w    = NW'(fac_sq);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [AsumW-1:0]  asum_q, asum_d;
  logic [WsumW-1:0]  wsum_q [3];
  logic [WsumW-1:0]  wsum_d [3];
  chan_t             smp_q [4];     // latched sample: red, green, blue, alpha
  chan_t             smp_d [4];
  chan_t             res_q [4];     // resolved pixel: red, green, blue, alpha
  chan_t             res_d [4];
  logic [1:0]        sel_q, sel_d;
  logic [2:0]        step_q, step_d;
  logic [DivW-1:0]   rem_q, rem_d;
  logic [DivW-1:0]   den_q, den_d;
  logic [ChanW-1:0]  quo_q, quo_d;
  logic              ovalid_q, ovalid_d;
  logic [31:0]       odata_q, odata_d;
  logic              pend_q, pend_d;   // resolved pixel waiting for the output slot

  logic s_acc, slot_free, passthru;

  assign slot_free     = !ovalid_q || m_axis_tready;
  assign passthru      = (fac == 3'd1);
  assign s_axis_tready = (state_q == ST_IDLE) && !pend_q && (!passthru || slot_free);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // Shared 8x8 multiplier: latched alpha times one latched color per MUL state.
  logic [1:0]  mul_sel;
  logic [15:0] prod;

  always_comb begin
    unique case (state_q)
      ST_MUL_G: mul_sel = SelGreen;
      ST_MUL_B: mul_sel = SelBlue;
      default:  mul_sel = SelRed;
    endcase
  end

  assign prod = {8'd0, smp_q[mul_sel]} * {8'd0, smp_q[SelAlpha]};

  // Shared restoring divider, one quotient bit per step.
  logic            ge;
  logic [DivW-1:0] num_w, dsr_w;
  logic [WsumW-1:0] wsum_sel;
  chan_t           quo_fin;

  assign ge      = (rem_q >= den_q);
  assign quo_fin = {quo_q[ChanW-2:0], ge};

  always_comb begin
    case (sel_q)
      SelGreen: wsum_sel = wsum_q[1];
      SelBlue:  wsum_sel = wsum_q[2];
      default:  wsum_sel = wsum_q[0];
    endcase
  end

  // Operands for round half up: (2x + d) / (2d), divisor pre-shifted for 8 steps.
  always_comb begin
    if (sel_q == SelAlpha) begin
      num_w = DivW'({asum_q, 1'b0}) + DivW'(n_w);
      dsr_w = DivW'({n_w, 1'b0}) << (ChanW - 1);
    end else begin
      num_w = DivW'({wsum_sel, 1'b0}) + DivW'(asum_q);
      dsr_w = DivW'({asum_q, 1'b0}) << (ChanW - 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    asum_d   = asum_q;
    wsum_d   = wsum_q;
    smp_d    = smp_q;
    res_d    = res_q;
    sel_d    = sel_q;
    step_d   = step_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    pend_d   = pend_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    // Resolved pixel moves to the output register once the slot frees.
    if (pend_q && slot_free) begin
      ovalid_d = 1'b1;
      odata_d  = {res_q[3], res_q[2], res_q[1], res_q[0]};
      pend_d   = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (passthru) begin
            ovalid_d = 1'b1;
            odata_d  = s_axis_tdata;
          end else begin
            smp_d[0] = s_axis_tdata[7:0];
            smp_d[1] = s_axis_tdata[15:8];
            smp_d[2] = s_axis_tdata[23:16];
            smp_d[3] = s_axis_tdata[31:24];
            asum_d   = asum_q + AsumW'(s_axis_tdata[31:24]);
            state_d  = ST_MUL_R;
          end
        end
      end
      ST_MUL_R: begin
        wsum_d[0] = wsum_q[0] + WsumW'(prod);
        state_d   = ST_MUL_G;
      end
      ST_MUL_G: begin
        wsum_d[1] = wsum_q[1] + WsumW'(prod);
        state_d   = ST_MUL_B;
      end
      ST_MUL_B: begin
        wsum_d[2] = wsum_q[2] + WsumW'(prod);
        if (NW'(cnt_q + NW'(1)) == n_w) begin
          sel_d   = SelRed;
          state_d = ST_LOAD;
        end else begin
          cnt_d   = cnt_q + NW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        rem_d   = num_w;
        den_d   = dsr_w;
        quo_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? (rem_q - den_q) : rem_q;
        den_d  = den_q >> 1;
        quo_d  = quo_fin;
        step_d = step_q + 3'd1;
        if (step_q == 3'(ChanW - 1)) begin
          // zero alpha sum: colors resolve to zero
          if (sel_q != SelAlpha && asum_q == '0) begin
            res_d[sel_q] = '0;
          end else begin
            res_d[sel_q] = quo_fin;
          end
          if (sel_q == SelAlpha) begin
            pend_d    = 1'b1;
            cnt_d     = '0;
            asum_d    = '0;
            wsum_d[0] = '0;
            wsum_d[1] = '0;
            wsum_d[2] = '0;
            state_d   = ST_IDLE;
          end else begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A factor write starts a new block.
    if (cfg_wr) begin
      cnt_d     = '0;
      asum_d    = '0;
      wsum_d[0] = '0;
      wsum_d[1] = '0;
      wsum_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      scale_q   <= 3'd1;
      cnt_q     <= '0;
      asum_q    <= '0;
      wsum_q[0] <= '0;
      wsum_q[1] <= '0;
      wsum_q[2] <= '0;
      sel_q     <= SelRed;
      step_q    <= '0;
      pend_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      scale_q  <= scale_d;
      cnt_q    <= cnt_d;
      asum_q   <= asum_d;
      wsum_q   <= wsum_d;
      sel_q    <= sel_d;
      step_q   <= step_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    res_q   <= res_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    odata_q <= odata_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Between samples the count stays below the block size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q < n_w))
    else $error("sample count reached block size while idle");

  // Restoring divider invariant: remainder below twice the shifted divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && den_q != '0) |-> (rem_q < (den_q << 1)))
    else $error("divider remainder out of range");

  // A pending pixel reaches the output register as soon as the slot frees.
  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && slot_free) |=> (ovalid_q && !pend_q))
    else $error("resolved pixel not handed to output");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for supersample_box_resolve: a directed table, then random sample blocks.
`timescale 1ns / 1ps

module tb
  import ssbr_pkg::*;
();

  localparam int unsigned MaxFactor    = 4;
  localparam int unsigned RandItems    = 1500;
  // 3 multiplier passes, 4 divides, output register, plus margin
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [2:0]  RegUnmapped  = 3'd4;   // a byte address outside the register map
  localparam bit NoCfg = 1'b0;
  localparam bit Cfg   = 1'b1;
  localparam bit Pred  = 1'b0;
  localparam bit Known = 1'b1;
  // factors for the first random phases: extremes first, every legal code once
  localparam logic [23:0] FactorOrder = {3'd6, 3'd3, 3'd5, 3'd2, 3'd0, 3'd4, 3'd1, 3'd7};

  // packed so that red sits in the low byte, as on the tdata buses
  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgba_t;

  typedef struct packed {
    logic  has_known;
    rgba_t known;
    rgba_t sample;
  } beat_t;

  typedef struct packed {
    logic       do_cfg;
    logic [2:0] addr;
    logic [2:0] value;
    rgba_t      sample;
    logic       has_known;
    rgba_t      known;
  } dir_row_t;

  typedef enum int {BlkRandom, BlkExtreme, BlkClear, BlkOpaque, BlkFaint} blk_style_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // sample_red, sample_green, sample_blue, sample_alpha
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // pixel_red, pixel_green, pixel_blue, pixel_alpha
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  supersample_box_resolve #(.MAX_FACTOR(MaxFactor)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Resolve predictor: register copy plus block accumulators.
  logic [2:0]  scale_reg = 3'd1;
  logic [4:0]  blk_count = '0;     // as wide as the block's count, so 16 does not wrap
  logic [11:0] blk_alpha = '0;
  logic [19:0] blk_red   = '0;
  logic [19:0] blk_green = '0;
  logic [19:0] blk_blue  = '0;

  beat_t       sample_q[$];        // samples waiting to be driven
  rgba_t       pixel_due_q[$];     // resolved pixels not yet seen on the output
  beat_t       cur_beat;
  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_on = 1'b1;

  function automatic bit count_error();
    err_cnt++;
    return 1'b1;
  endfunction

  function automatic int unsigned effective_factor(logic [2:0] code);
    if (code == 3'd0) return 1;
    if (32'(code) > MaxFactor) return MaxFactor;
    return 32'(code);
  endfunction

  function automatic void clear_block();
    blk_count = '0;
    blk_alpha = '0;
    blk_red   = '0;
    blk_green = '0;
    blk_blue  = '0;
  endfunction

  // floor(num / den + 1/2)
  function automatic logic [31:0] round_half_up(logic [31:0] num, logic [31:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic chan_t weighted_color(logic [19:0] wsum);
    logic [31:0] q;
    if (blk_alpha == '0) return '0;
    q = round_half_up(32'(wsum), 32'(blk_alpha));
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // Returns 1 when the sample completes a pixel, which then lands in px.
  function automatic bit resolve_sample(rgba_t s, output rgba_t px);
    int unsigned f;
    int unsigned n;
    logic [31:0] pa;
    px = '0;
    f = effective_factor(scale_reg);
    if (f == 1) begin
      px = s;
      return 1'b1;
    end
    n = f * f;
    blk_alpha = blk_alpha + {4'b0, s.alpha};
    blk_red   = blk_red   + {12'b0, s.red}   * {12'b0, s.alpha};
    blk_green = blk_green + {12'b0, s.green} * {12'b0, s.alpha};
    blk_blue  = blk_blue  + {12'b0, s.blue}  * {12'b0, s.alpha};
    blk_count = blk_count + 5'd1;
    if (32'(blk_count) < n) return 1'b0;
    pa = round_half_up(32'(blk_alpha), n);
    px.alpha = (pa > 255) ? 8'hFF : pa[7:0];
    px.red   = weighted_color(blk_red);
    px.green = weighted_color(blk_green);
    px.blue  = weighted_color(blk_blue);
    clear_block();
    return 1'b1;
  endfunction

  function automatic void check_chan(string name, chan_t want, chan_t got);
    if (got !== want && count_error())
      $display("%0t: pixel %s mismatch: expected %0d, got %0d", $time, name, want, got);
  endfunction

  // Sample source: predicts on every accepted beat, inserts random gaps between beats.
  always @(posedge clk_i) begin : sample_source
    rgba_t px;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        accepted_cnt++;
        if (resolve_sample(cur_beat.sample, px))
          pixel_due_q.push_back(cur_beat.has_known ? cur_beat.known : px);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur_beat = sample_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_beat.sample;
          if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Pixel sink: compares each beat with the oldest resolved pixel, stalls in bursts.
  always @(posedge clk_i) begin : pixel_sink
    rgba_t got;
    rgba_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pixel_due_q.size() == 0) begin
          if (count_error())
            $display("%0t: unexpected pixel: expected none, got %h", $time, got);
        end else begin
          want = pixel_due_q.pop_front();
          check_chan("red", want.red, got.red);
          check_chan("green", want.green, got.green);
          check_chan("blue", want.blue, got.blue);
          check_chan("alpha", want.alpha, got.alpha);
        end
      end
      if (snk_gap != 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One APB transfer: setup, then access until pready.
  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write with random upper data bits; the mapped register is read back.
  task automatic set_register(logic [2:0] addr, logic [2:0] value);
    logic [31:0] data;
    logic [31:0] rdata;
    data = $urandom;
    data[2:0] = value;
    apb_access(1'b1, addr, data, rdata);
    if (addr == RegScaleFactor) begin
      scale_reg = value;
      clear_block();
      apb_access(1'b0, addr, '0, rdata);
      if (rdata !== {29'b0, scale_reg} && count_error())
        $display("%0t: scale_factor readback mismatch: expected %0d, got %0d",
                 $time, scale_reg, rdata);
    end
  endtask

  // Block must be idle before a register write: all beats in, all pixels out, divider done.
  task automatic settle();
    while (accepted_cnt != pushed_cnt || pixel_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void queue_sample(rgba_t s, bit has_known, rgba_t known);
    beat_t b;
    b = {has_known, known, s};
    sample_q.push_back(b);
    pushed_cnt++;
  endfunction

  task automatic queue_block(int unsigned len, blk_style_e style);
    rgba_t s;
    for (int unsigned i = 0; i < len; i++) begin
      s = $urandom;
      case (style)
        BlkExtreme: s = {{8{s[31]}}, {8{s[23]}}, {8{s[15]}}, {8{s[7]}}};
        BlkClear:   s.alpha = 8'h00;
        BlkOpaque:  s.alpha = 8'hFF;
        BlkFaint:   s.alpha = 8'($urandom_range(0, 3));   // small sums, rounding edges
        default:    ;
      endcase
      queue_sample(s, Pred, '0);
    end
  endtask

  initial begin : stimulus
    dir_row_t    dir_rows[$];
    dir_row_t    row;
    int unsigned rand_done;
    int unsigned phase;
    int unsigned n;
    int unsigned blocks;
    int unsigned len;
    logic [2:0]  factor;
    blk_style_e  style;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cfg, addr, factor, sample (ABGR hex), known?, known pixel (ABGR hex)
    // factor 1 after reset: pass-through, color kept even at zero alpha
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00000000, Known, 32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'hFFFFFFFF, Known, 32'hFFFFFFFF});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00563412, Known, 32'h00563412});
    // factor 2, all channels at full scale
    dir_rows.push_back({Cfg,   RegScaleFactor, 3'd2, 32'hFFFFFFFF, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'hFFFFFFFF, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'hFFFFFFFF, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'hFFFFFFFF, Known, 32'hFFFFFFFF});
    // exact halves round up; an unmapped write mid-block must not disturb the sums
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h01FF000A, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h01FE000B, Pred,  32'h00000000});
    dir_rows.push_back({Cfg,   RegUnmapped,    3'd3, 32'h003264C8, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00090807, Known, 32'h01FF000B});
    // half a block, then a rewrite of the factor drops it; zero alpha sum gives black
    dir_rows.push_back({Cfg,   RegScaleFactor, 3'd2, 32'hFF808080, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'hFF808080, Pred,  32'h00000000});
    dir_rows.push_back({Cfg,   RegScaleFactor, 3'd2, 32'h00FFFFFF, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00000000, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00AA55AA, Pred,  32'h00000000});
    dir_rows.push_back({NoCfg, RegScaleFactor, 3'd0, 32'h00123456, Known, 32'h00000000});
    // factor code zero behaves as one
    dir_rows.push_back({Cfg,   RegScaleFactor, 3'd0, 32'h80C0FF01, Known, 32'h80C0FF01});

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.do_cfg) begin
        settle();
        set_register(row.addr, row.value);
      end
      queue_sample(row.sample, row.has_known, row.known);
    end

    // Random phases: one factor each, mostly whole blocks, sometimes a cut-off tail.
    rand_done = 0;
    phase = 0;
    while (rand_done < RandItems) begin
      settle();
      if (phase < 8) factor = FactorOrder[3*phase +: 3];
      else factor = 3'($urandom_range(0, 7));
      set_register(RegScaleFactor, factor);
      // quiet stretches now and then; none near the end
      idle_on = (rand_done < RandItems * 4 / 5) && ($urandom_range(0, 3) != 0);
      n = effective_factor(factor) * effective_factor(factor);
      blocks = (n == 1) ? 80 : $urandom_range(2, 120 / n + 1);
      for (int unsigned b = 0; b < blocks; b++) begin
        len = n;
        if (b == blocks - 1 && n > 1 && $urandom_range(0, 3) == 0)
          len = $urandom_range(1, n - 1);
        case ($urandom_range(0, 9))
          0:       style = BlkExtreme;
          1:       style = BlkClear;
          2:       style = BlkOpaque;
          3:       style = BlkFaint;
          default: style = BlkRandom;
        endcase
        queue_block(len, style);
        rand_done += len;
        // partial block: either left for the next factor write to drop, or
        // finished after a write to an unmapped address
        if (len < n && $urandom_range(0, 1) == 1) begin
          settle();
          set_register(RegUnmapped, 3'($urandom_range(0, 7)));
          queue_block(n - len, style);
          rand_done += n - len;
        end
      end
      phase++;
    end

    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
